### rtl/core/double_valve_interlock_controller_defines.svh
`ifndef DOUBLE_VALVE_INTERLOCK_CONTROLLER_DEFINES_SVH
`define DOUBLE_VALVE_INTERLOCK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DVIC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DVIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/dvic_pkg.sv
package dvic_pkg;

	localparam int unsigned REG_IDX_W  = 2;
	localparam int unsigned REG_DATA_W = 2;

	// Configuration register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_PRESENT   = 2'd0,
		REG_HOLD_MODE = 2'd1,
		REG_DIAG      = 2'd2
	} cfg_reg_t;

	// Self-hold modes for the drives
	typedef enum logic [1:0] {
		HOLD_NONE   = 2'd0,
		HOLD_SENSOR = 2'd1,
		HOLD_ALWAYS = 2'd2,
		HOLD_SUPPLY = 2'd3
	} hold_mode_t;

	// Alarm bit positions
	localparam int unsigned ALM_OUT1    = 0;
	localparam int unsigned ALM_OUT1A   = 1;
	localparam int unsigned ALM_OUT1B   = 2;
	localparam int unsigned ALM_OUT2    = 3;
	localparam int unsigned ALM_OUT2A   = 4;
	localparam int unsigned ALM_OUT2B   = 5;
	localparam int unsigned ALM_OVERLAP = 6;

	// Pending command bit positions
	localparam int unsigned CMD_STOP  = 0;
	localparam int unsigned CMD_MOVE1 = 1;
	localparam int unsigned CMD_MOVE2 = 2;

	typedef struct packed {
		logic       alarm_reset;
		logic [1:0] machine_ok;
		logic [1:0] fault_timeout;
		logic [1:0] sensors;
		logic       overlap_timeout;
		logic       manual_mode;
		logic [1:0] manual_request;
		logic       auto_cycle;
		logic       auto_clear;
		logic [2:0] command_set;
		logic       supply_ok;
		logic [1:0] done_gate;
	} scan_t;

	typedef struct packed {
		logic [1:0] drive;
		logic [6:0] alarms;
		logic       hold_axes;
		logic [1:0] motion_done;
		logic [1:0] auto_active;
		logic [2:0] commands_pending;
	} result_t;

	typedef struct packed {
		logic [1:0] drive_bits;
		logic [1:0] command_bits;
		logic [1:0] auto_bits;
		logic [2:0] pending_commands;
		logic [6:0] alarm_bits;
	} state_t;

	typedef struct packed {
		logic       component_present;
		hold_mode_t hold_mode;
		logic       two_sensor_diag;
	} cfg_t;

endpackage

### rtl/core/dvic_scan_if.sv
interface dvic_scan_if;
	import dvic_pkg::*;

	logic  valid;
	logic  ready;
	scan_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/dvic_result_if.sv
interface dvic_result_if;
	import dvic_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/dvic_scan_logic.sv
module dvic_scan_logic (
	input  dvic_pkg::cfg_t    cfg,
	input  dvic_pkg::state_t  cur,
	input  dvic_pkg::scan_t   item,
	output dvic_pkg::state_t  nxt,
	output dvic_pkg::result_t res
);
	import dvic_pkg::*;

	logic [2:0] pend;
	logic [6:0] alm;
	logic       d1, d2, c1, c2, a1, a2, s1, s2;
	logic       m0, m1, m2, na1, na2;
	logic       con1, con2, ovlal, nc1, nc2, nd1, nd2;
	logic       hold, done_b, done_a;

	always_comb begin
		pend = cur.pending_commands | item.command_set;
		d1 = cur.drive_bits[0];
		d2 = cur.drive_bits[1];
		c1 = cur.command_bits[0];
		c2 = cur.command_bits[1];
		a1 = cur.auto_bits[0];
		a2 = cur.auto_bits[1];
		s1 = item.sensors[0];
		s2 = item.sensors[1];

		// interlock against previous scan
		if (cfg.hold_mode != HOLD_NONE) begin
			con1 = item.machine_ok[0] & ~c2;
			con2 = item.machine_ok[1] & ~c1;
		end else begin
			con1 = item.machine_ok[0] & ~d2;
			con2 = item.machine_ok[1] & ~d1;
		end

		alm = item.alarm_reset ? 7'd0 : cur.alarm_bits;
		if (!cfg.two_sensor_diag) begin
			alm[ALM_OUT1] = alm[ALM_OUT1] | item.fault_timeout[0];
			alm[ALM_OUT2] = alm[ALM_OUT2] | item.fault_timeout[1];
		end else begin
			alm[ALM_OUT1B] = alm[ALM_OUT1B] | (item.fault_timeout[0] & s2);
			alm[ALM_OUT1A] = alm[ALM_OUT1A] | (item.fault_timeout[0] & ~s2);
			alm[ALM_OUT2B] = alm[ALM_OUT2B] | (item.fault_timeout[1] & s1);
			alm[ALM_OUT2A] = alm[ALM_OUT2A] | (item.fault_timeout[1] & ~s1);
		end
		alm[ALM_OVERLAP] = alm[ALM_OVERLAP] | item.overlap_timeout;
		ovlal = alm[ALM_OVERLAP];

		// pending command clear rules
		m0 = pend[CMD_STOP] & (a1 | a2) & item.auto_cycle;
		m1 = pend[CMD_MOVE1] & ~(s1 & a1) & item.auto_cycle;
		m2 = pend[CMD_MOVE2] & ~(s2 & a2) & item.auto_cycle;

		na1 = (m1 | a1) & item.auto_cycle & ~item.auto_clear & ~m2 & ~m0;
		na2 = (m2 | a2) & item.auto_cycle & ~item.auto_clear & ~m1 & ~m0;

		nc1 = (item.manual_mode & item.manual_request[0] & con1) | (na1 & con1 & ~ovlal);
		nc2 = (item.manual_mode & item.manual_request[1] & con2) | (na2 & con2 & ~ovlal);

		case (cfg.hold_mode)
			HOLD_NONE: begin
				nd1 = nc1 & ~nc2;
				nd2 = nc2 & ~nc1;
			end
			HOLD_SENSOR: begin
				nd1 = (nc1 | (d1 & s1)) & ~nc2;
				nd2 = (nc2 | (d2 & s2)) & ~nc1;
			end
			HOLD_ALWAYS: begin
				nd1 = (nc1 | d1) & ~nc2;
				nd2 = (nc2 | d2) & ~nc1;
			end
			HOLD_SUPPLY: begin
				nd1 = (nc1 | (d1 & item.supply_ok)) & ~nc2;
				nd2 = (nc2 | (d2 & item.supply_ok)) & ~nc1;
			end
			default: begin
				nd1 = 1'b0;
				nd2 = 1'b0;
			end
		endcase

		hold   = |alm;
		done_b = item.done_gate[0] & (s1 | (item.done_gate[1] & nd1));
		done_a = item.done_gate[0] & (s2 | (item.done_gate[1] & nd2));

		if (cfg.component_present) begin
			nxt.drive_bits       = {nd2, nd1};
			nxt.command_bits     = {nc2, nc1};
			nxt.auto_bits        = {na2, na1};
			nxt.pending_commands = {m2, m1, m0};
			nxt.alarm_bits       = alm;
			res.hold_axes        = hold;
			res.motion_done      = {done_a, done_b};
		end else begin
			// absent: keep drives, drop alarms and move commands
			nxt.drive_bits       = cur.drive_bits;
			nxt.command_bits     = cur.command_bits;
			nxt.auto_bits        = cur.auto_bits;
			nxt.pending_commands = {2'b00, pend[CMD_STOP]};
			nxt.alarm_bits       = 7'd0;
			res.hold_axes        = 1'b0;
			res.motion_done      = 2'b00;
		end

		res.drive            = nxt.drive_bits;
		res.alarms           = nxt.alarm_bits;
		res.auto_active      = nxt.auto_bits;
		res.commands_pending = nxt.pending_commands;
	end
endmodule

### rtl/core/double_valve_interlock_controller.sv
// Double-valve interlock controller: one control scan per transfer on the scan
// channel, one result per scan on the result channel, in the same order.
// Channels: scan (sink) carries the sensor, timeout, command and mode inputs
// of one scan; result (source) carries drives, sticky alarms, axis hold,
// motion-done flags, automatic hold bits and pending commands after the scan.
// Configuration: wr_en/wr_index/wr_data write component_present (0),
// hold_mode (1) and two_sensor_diag (2); other indexes are ignored. Write only
// while no scan is in flight.
// Path: an accepted scan is registered in the input stage, evaluated against the
// stored state and written to the result register once that register is free.
// Throughput: one scan per cycle while the result channel does not stall; the
// whole scan is a few gates of logic on a handful of state bits.
// Reset (arst_n low): all state, configuration and valid flags clear; no
// result is shown until a scan is accepted.
// Stall: while a result waits, one more scan may be held in the input stage;
// then scan.ready drops until the result transfer completes.
module double_valve_interlock_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [dvic_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [dvic_pkg::REG_DATA_W-1:0]    wr_data,
	dvic_scan_if.sink                          scan,
	dvic_result_if.source                      result
);
	import dvic_pkg::*;

	// Input stage
	scan_t   scan_s1;
	logic    valid_s1;

	// Scan state and configuration
	state_t  state_q;
	state_t  state_nxt;
	cfg_t    cfg_q;

	// Result register
	result_t result_q;
	result_t result_nxt;
	logic    result_valid_q;

	logic    advance;

	// The input stage moves on when the result register is free or draining.
	assign advance     = valid_s1 & (~result_valid_q | result.ready);
	assign scan.ready  = ~valid_s1 | advance;

	assign result.valid = result_valid_q;
	assign result.data  = result_q;

	dvic_scan_logic u_scan_logic (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (scan_s1),
		.nxt  (state_nxt),
		.res  (result_nxt)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{component_present: 1'b0, hold_mode: HOLD_NONE, two_sensor_diag: 1'b0};
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PRESENT:   cfg_q.component_present <= wr_data[0];
				REG_HOLD_MODE: cfg_q.hold_mode <= hold_mode_t'(wr_data[1:0]);
				REG_DIAG:      cfg_q.two_sensor_diag <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			scan_s1 <= scan.data;
		end
	end

	// Scan state: updated once per evaluated scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end
endmodule

### rtl/core/dvic_checker.sv
`include "double_valve_interlock_controller_defines.svh"

module dvic_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic [1:0] drive,
	input logic [6:0] alarms,
	input logic       hold_axes,
	input logic [1:0] auto_active
);
	// Both outputs are never energized together.
	`DVIC_ASSERT_NOW(a_drive_excl, clk, arst_n, result_valid, drive != 2'b11, "both drives on")

	// Both automatic hold bits are never set together.
	`DVIC_ASSERT_NOW(a_auto_excl, clk, arst_n, result_valid, auto_active != 2'b11, "both auto bits on")

	// Axis hold is exactly "some alarm latched".
	`DVIC_ASSERT_NOW(a_hold_alarm, clk, arst_n, result_valid, hold_axes == (alarms != 7'd0), "hold_axes mismatch")

	// A stalled result stays offered.
	`DVIC_ASSERT_NEXT(a_res_hold, clk, arst_n, result_valid && !result_ready, result_valid, "result dropped")
endmodule

bind double_valve_interlock_controller dvic_checker u_dvic_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.drive        (result.data.drive),
	.alarms       (result.data.alarms),
	.hold_axes    (result.data.hold_axes),
	.auto_active  (result.data.auto_active)
);

### dv/tb.sv
`timescale 1ns / 1ps

// Scan-level check of the double-valve interlock controller.
// Scans go in through a queue that the stimulus block fills; a clocked driver
// feeds them onto the scan channel with random gaps, and a clocked monitor
// runs its own model of the controller on every accepted scan and checks every
// result transfer against the oldest predicted result.
module tb;
	import dvic_pkg::*;

	// Index 3 is not a register; writes to it must be ignored.
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int unsigned PHASES = 10;
	localparam int unsigned PHASE_SCANS = 172;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Config write port, driven only by write_reg()
	logic                  wr_en = 1'b0;
	logic [REG_IDX_W-1:0]  wr_index = '0;
	logic [REG_DATA_W-1:0] wr_data = '0;

	// Channel drive, held in local variables so everything is known at time 0
	logic  scan_valid = 1'b0;
	scan_t scan_data = '0;
	logic  result_ready = 1'b0;

	dvic_scan_if   scan_ch ();
	dvic_result_if res_ch ();

	assign scan_ch.valid = scan_valid;
	assign scan_ch.data  = scan_data;
	assign res_ch.ready  = result_ready;

	double_valve_interlock_controller u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.scan     (scan_ch),
		.result   (res_ch)
	);

	always #10 clk = ~clk;

	// Scans waiting to be driven, and results predicted but not yet seen
	scan_t   scan_q[$];
	result_t due_results[$];

	// Model copy of the configuration registers
	logic       cfg_present = 1'b0;
	hold_mode_t cfg_hold = HOLD_NONE;
	logic       cfg_diag = 1'b0;

	// Model copy of the controller state carried between scans
	logic [1:0] valve_drive = '0;
	logic [1:0] valve_cmd = '0;
	logic [1:0] auto_hold = '0;
	logic [2:0] cmd_pending = '0;
	logic [6:0] alarm_latch = '0;

	logic scan_fire = 1'b0;      // scan transfer seen at the last rising edge
	int   src_gap = 0;
	int   sink_stall = 0;
	bit   src_steady = 1'b0;     // no source gaps in this phase
	bit   sink_steady = 1'b0;    // no sink stalls in this phase
	int   mismatch_cnt = 0;

	// One control scan. Interlock terms use the previous scan's command/drive
	// bits, so they are formed before anything is updated.
	function automatic result_t run_scan(input scan_t s);
		result_t r;
		logic [2:0] m;
		logic con1, con2, ovl_latched, na1, na2, nc1, nc2, nd1, nd2;
		logic hold, done_b, done_a;
		hold = 1'b0;
		done_b = 1'b0;
		done_a = 1'b0;
		cmd_pending = cmd_pending | s.command_set;
		if (cfg_present) begin
			m = cmd_pending;
			if (s.alarm_reset)
				alarm_latch = '0;
			// self-hold modes interlock on the opposite command, plain mode on the
			// opposite drive
			con1 = s.machine_ok[0] &&
				((cfg_hold != HOLD_NONE) ? !valve_cmd[1] : !valve_drive[1]);
			con2 = s.machine_ok[1] &&
				((cfg_hold != HOLD_NONE) ? !valve_cmd[0] : !valve_drive[0]);
			if (!cfg_diag) begin
				if (s.fault_timeout[0]) alarm_latch[ALM_OUT1] = 1'b1;
				if (s.fault_timeout[1]) alarm_latch[ALM_OUT2] = 1'b1;
			end else begin
				// classify by the opposite sensor
				if (s.fault_timeout[0])
					alarm_latch[s.sensors[1] ? ALM_OUT1B : ALM_OUT1A] = 1'b1;
				if (s.fault_timeout[1])
					alarm_latch[s.sensors[0] ? ALM_OUT2B : ALM_OUT2A] = 1'b1;
			end
			if (s.overlap_timeout)
				alarm_latch[ALM_OVERLAP] = 1'b1;
			ovl_latched = alarm_latch[ALM_OVERLAP];
			// pending command clear rules
			if ((s.sensors[0] && auto_hold[0]) || !s.auto_cycle) m[CMD_MOVE1] = 1'b0;
			if ((s.sensors[1] && auto_hold[1]) || !s.auto_cycle) m[CMD_MOVE2] = 1'b0;
			if (auto_hold == 2'b00 || !s.auto_cycle) m[CMD_STOP] = 1'b0;
			na1 = (m[CMD_MOVE1] || auto_hold[0]) && s.auto_cycle && !s.auto_clear &&
				!m[CMD_MOVE2] && !m[CMD_STOP];
			na2 = (m[CMD_MOVE2] || auto_hold[1]) && s.auto_cycle && !s.auto_clear &&
				!m[CMD_MOVE1] && !m[CMD_STOP];
			hold = (alarm_latch != '0);
			nc1 = (s.manual_mode && s.manual_request[0] && con1) ||
				(na1 && con1 && !ovl_latched);
			nc2 = (s.manual_mode && s.manual_request[1] && con2) ||
				(na2 && con2 && !ovl_latched);
			// both commands on: neither drive
			case (cfg_hold)
				HOLD_NONE: begin
					nd1 = nc1 && !nc2;
					nd2 = nc2 && !nc1;
				end
				HOLD_SENSOR: begin
					nd1 = (nc1 || (valve_drive[0] && s.sensors[0])) && !nc2;
					nd2 = (nc2 || (valve_drive[1] && s.sensors[1])) && !nc1;
				end
				HOLD_ALWAYS: begin
					nd1 = (nc1 || valve_drive[0]) && !nc2;
					nd2 = (nc2 || valve_drive[1]) && !nc1;
				end
				default: begin
					nd1 = (nc1 || (valve_drive[0] && s.supply_ok)) && !nc2;
					nd2 = (nc2 || (valve_drive[1] && s.supply_ok)) && !nc1;
				end
			endcase
			done_b = s.done_gate[0] && (s.sensors[0] || (s.done_gate[1] && nd1));
			done_a = s.done_gate[0] && (s.sensors[1] || (s.done_gate[1] && nd2));
			valve_drive = {nd2, nd1};
			valve_cmd   = {nc2, nc1};
			auto_hold   = {na2, na1};
			cmd_pending = m;
		end else begin
			// component absent: alarms and moves drop, stop stays, drives freeze
			alarm_latch = '0;
			cmd_pending[CMD_MOVE1] = 1'b0;
			cmd_pending[CMD_MOVE2] = 1'b0;
		end
		r.drive            = valve_drive;
		r.alarms           = alarm_latch;
		r.hold_axes        = hold;
		r.motion_done      = {done_a, done_b};
		r.auto_active      = auto_hold;
		r.commands_pending = cmd_pending;
		return r;
	endfunction

	// Idle length: idle_pct percent none, most others short, a few long.
	function automatic int pick_gap(input int unsigned idle_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < idle_pct)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Mostly well-formed scans (auto cycle on, machine permits, one command at a
	// time, rare faults); one in ten is raw noise.
	function automatic scan_t gen_scan();
		scan_t s;
		logic [31:0] raw;
		raw = $urandom;
		s = raw[$bits(scan_t)-1:0];
		if ($urandom_range(0, 9) == 0)
			return s;
		s.alarm_reset     = ($urandom_range(0, 9) == 0);
		s.machine_ok[0]   = ($urandom_range(0, 9) != 0);
		s.machine_ok[1]   = ($urandom_range(0, 9) != 0);
		s.fault_timeout[0] = ($urandom_range(0, 19) == 0);
		s.fault_timeout[1] = ($urandom_range(0, 19) == 0);
		s.overlap_timeout = ($urandom_range(0, 29) == 0);
		s.manual_mode     = ($urandom_range(0, 3) == 0);
		s.auto_cycle      = ($urandom_range(0, 9) != 0);
		s.auto_clear      = ($urandom_range(0, 19) == 0);
		s.supply_ok       = ($urandom_range(0, 4) != 0);
		case ($urandom_range(0, 9))
			0, 1:    s.command_set = 3'b001 << CMD_MOVE1;
			2, 3:    s.command_set = 3'b001 << CMD_MOVE2;
			4:       s.command_set = 3'b001 << CMD_STOP;
			5:       s.command_set = raw[31:29];
			default: s.command_set = '0;
		endcase
		return s;
	endfunction

	// Config write at the falling edge; lands at the next rising edge.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
		input logic [REG_DATA_W-1:0] val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_PRESENT:   cfg_present = val[0];
			REG_HOLD_MODE: cfg_hold = hold_mode_t'(val);
			REG_DIAG:      cfg_diag = val[0];
			default: ;
		endcase
	endtask

	// Hold off until every queued scan has been sent and every result is back.
	// Checked just after the falling edge, once the driver's updates settled.
	task automatic drain();
		while (scan_q.size() != 0 || scan_valid || due_results.size() != 0) begin
			@(negedge clk);
			#1;
		end
	endtask

	// Scan driver: next scan goes out once the current one transferred.
	always @(negedge clk) begin : drive_scan
		logic  nxt_valid;
		scan_t nxt_data;
		nxt_valid = scan_valid;
		nxt_data  = scan_data;
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else if (!scan_valid || scan_fire) begin
			nxt_valid = 1'b0;
			if (src_gap > 0) begin
				src_gap--;
			end else if (scan_q.size() != 0) begin
				nxt_data  = scan_q.pop_front();
				nxt_valid = 1'b1;
				src_gap   = src_steady ? 0 : pick_gap(55);
			end
		end
		scan_valid <= nxt_valid;
		scan_data  <= nxt_data;
	end

	// Result sink: random stalls of random length.
	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (sink_stall > 0) begin
			sink_stall--;
			result_ready <= 1'b0;
		end else begin
			sink_stall = sink_steady ? 0 : pick_gap(70);
			result_ready <= (sink_stall == 0);
			if (sink_stall > 0)
				sink_stall--;
		end
	end

	// Monitor: check result transfers, then predict for a new scan transfer.
	always @(posedge clk) begin : monitor
		result_t want;
		result_t got;
		if (!arst_n) begin
			scan_fire <= 1'b0;
		end else begin
			scan_fire <= scan_ch.valid && scan_ch.ready;
			if (res_ch.valid && res_ch.ready) begin
				got = res_ch.data;
				if (due_results.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: result transfer with no scan outstanding: %h",
							$realtime, got);
				end else begin
					want = due_results.pop_front();
					if (got.drive !== want.drive || got.alarms !== want.alarms ||
						got.hold_axes !== want.hold_axes ||
						got.motion_done !== want.motion_done ||
						got.auto_active !== want.auto_active ||
						got.commands_pending !== want.commands_pending) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("%0t: result mismatch", $realtime);
							$display(
								"  expected drive=%b alarms=%b hold=%b done=%b auto=%b cmds=%b",
								want.drive, want.alarms, want.hold_axes, want.motion_done,
								want.auto_active, want.commands_pending);
							$display(
								"  actual   drive=%b alarms=%b hold=%b done=%b auto=%b cmds=%b",
								got.drive, got.alarms, got.hold_axes, got.motion_done,
								got.auto_active, got.commands_pending);
						end
					end
				end
			end
			if (scan_ch.valid && scan_ch.ready)
				due_results.push_back(run_scan(scan_ch.data));
		end
	end

	initial begin : stimulus
		scan_t s;
		logic  pres;
		logic [1:0] hm;
		logic  diag;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// Component absent after reset: moves dropped, stop kept, alarms cleared.
		s = '0; s.command_set = 3'b111; s.fault_timeout = 2'b11; s.overlap_timeout = 1'b1;
		scan_q.push_back(s);
		s = '1;
		scan_q.push_back(s);
		drain();
		write_reg(REG_PRESENT, 2'b11);   // upper data bit ignored
		write_reg(REG_HOLD_MODE, HOLD_NONE);
		write_reg(REG_DIAG, 2'b00);
		s = '0;
		scan_q.push_back(s);              // auto cycle off clears stop
		s = '0; s.fault_timeout = 2'b11; s.overlap_timeout = 1'b1;
		scan_q.push_back(s);              // plain timeout alarms plus overlap
		s = '0; s.alarm_reset = 1'b1;
		scan_q.push_back(s);
		// automatic move 1, then sensor reached, then move 2 against live drive 1
		s = '0; s.auto_cycle = 1'b1; s.machine_ok = 2'b11;
		s.command_set = 3'b001 << CMD_MOVE1;
		scan_q.push_back(s);
		s = '0; s.auto_cycle = 1'b1; s.machine_ok = 2'b11; s.sensors = 2'b01;
		s.done_gate = 2'b01;
		scan_q.push_back(s);
		s = '0; s.auto_cycle = 1'b1; s.machine_ok = 2'b11;
		s.command_set = 3'b001 << CMD_MOVE2;
		scan_q.push_back(s);
		s = '0; s.auto_cycle = 1'b1; s.machine_ok = 2'b11; s.done_gate = 2'b11;
		scan_q.push_back(s);
		s = '0; s.auto_cycle = 1'b1; s.machine_ok = 2'b11;
		s.command_set = 3'b001 << CMD_STOP;
		scan_q.push_back(s);
		// manual: both requested is a command conflict, then output 1 only
		s = '0; s.manual_mode = 1'b1; s.manual_request = 2'b11; s.machine_ok = 2'b11;
		scan_q.push_back(s);
		s = '0; s.manual_mode = 1'b1; s.manual_request = 2'b01; s.machine_ok = 2'b11;
		scan_q.push_back(s);
		s = '0; s.auto_cycle = 1'b1; s.auto_clear = 1'b1; s.machine_ok = 2'b11;
		s.command_set = 3'b001 << CMD_MOVE1;
		scan_q.push_back(s);
		// overlap alarm blocks the automatic command
		s = '0; s.auto_cycle = 1'b1; s.overlap_timeout = 1'b1; s.machine_ok = 2'b11;
		s.command_set = 3'b001 << CMD_MOVE1;
		scan_q.push_back(s);
		s = '0; s.alarm_reset = 1'b1; s.fault_timeout = 2'b11;
		scan_q.push_back(s);              // reset and relatch in one scan
		drain();
		write_reg(REG_DIAG, 2'b11);
		write_reg(REG_HOLD_MODE, HOLD_ALWAYS);
		s = '0; s.alarm_reset = 1'b1; s.fault_timeout = 2'b11;
		scan_q.push_back(s);              // opposite sensor off
		s = '0; s.fault_timeout = 2'b11; s.sensors = 2'b11;
		scan_q.push_back(s);              // opposite sensor on
		s = '0; s.alarm_reset = 1'b1; s.manual_mode = 1'b1; s.manual_request = 2'b01;
		s.machine_ok = 2'b11;
		scan_q.push_back(s);
		s = '0;
		scan_q.push_back(s);              // unconditional self-hold
		drain();
		write_reg(REG_HOLD_MODE, HOLD_SENSOR);
		s = '0; s.sensors = 2'b01;
		scan_q.push_back(s);
		s = '0;
		scan_q.push_back(s);
		drain();
		write_reg(REG_HOLD_MODE, HOLD_SUPPLY);
		write_reg(REG_DIAG, 2'b00);
		s = '0; s.manual_mode = 1'b1; s.manual_request = 2'b10; s.machine_ok = 2'b11;
		scan_q.push_back(s);
		s = '0; s.supply_ok = 1'b1;
		scan_q.push_back(s);
		s = '0;
		scan_q.push_back(s);
		drain();
		write_reg(REG_PRESENT, 2'b00);
		write_reg(REG_SPARE, 2'b11);
		s = '0; s.command_set = 3'b111;
		scan_q.push_back(s);              // absent: drives frozen
		drain();

		// --- random phases, extremes of the configuration first ---
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin pres = 1'b1; hm = HOLD_NONE;   diag = 1'b0; end
				1: begin pres = 1'b1; hm = HOLD_SUPPLY; diag = 1'b1; end
				2: begin pres = 1'b1; hm = HOLD_SENSOR; diag = 1'b0; end
				3: begin pres = 1'b1; hm = HOLD_ALWAYS; diag = 1'b1; end
				4: begin pres = 1'b0; hm = HOLD_SUPPLY; diag = 1'b1; end
				5: begin pres = 1'b1; hm = HOLD_NONE;   diag = 1'b1; end
				default: begin
					pres = ($urandom_range(0, 6) != 0);
					hm   = 2'($urandom_range(0, 3));
					diag = 1'($urandom_range(0, 1));
				end
			endcase
			drain();
			write_reg(REG_PRESENT, {1'b0, pres});
			write_reg(REG_HOLD_MODE, hm);
			write_reg(REG_DIAG, {1'b0, diag});
			src_steady  = (p % 3 == 0);
			sink_steady = (p % 3 == 1);
			for (int i = 0; i < PHASE_SCANS; i++) begin
				scan_q.push_back(gen_scan());
				// sender holds mid-phase until every result is back
				if (p % 2 == 0 && i == PHASE_SCANS / 2)
					drain();
			end
		end

		drain();
		repeat (4) @(negedge clk);
		mismatch_cnt += due_results.size();
		if (mismatch_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
